// ===== hdl/tef_pkg.sv =====
// ----------------------------------------------------------------------------
// tef_pkg
// Shared types and character constants for the text escape filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tef_pkg;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PCT,
        PH_ESC,
        PH_DIG1,
        PH_DIG2
    } t_phase;

    // one queued command: up to two result items sharing flags
    typedef struct packed {
        logic       two;    // percent plus byte, two results
        logic [7:0] b0;     // first result byte
        logic [7:0] b1;     // second result byte
        logic       v0;     // first result carries a character
        logic       eot;    // command closes the text
        logic       ovr;    // overscore flag
        logic       und;    // underscore flag
    } t_cmd;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    localparam int C_QUEUE_DEPTH = 2;

    localparam logic [7:0] C_PCT         = 8'h25;
    localparam logic [7:0] C_CODE_D      = 8'd31;
    localparam logic [7:0] C_CODE_P      = 8'd30;
    localparam logic [7:0] C_CODE_C      = 8'd29;
    localparam logic [7:0] C_CH_ZERO     = 8'd48;
    localparam logic [7:0] C_CH_NINE     = 8'd57;
    localparam logic [7:0] C_HUNDRED     = 8'd100;
    localparam logic [7:0] C_TEN         = 8'd10;
    localparam logic [7:0] C_LOWER_A     = 8'h61;
    localparam logic [7:0] C_LOWER_Z     = 8'h7A;
    localparam logic [7:0] C_CASE_OFFSET = 8'd32;
    localparam logic [7:0] C_CH_O        = 8'h4F;
    localparam logic [7:0] C_CH_U        = 8'h55;
    localparam logic [7:0] C_CH_D        = 8'h44;
    localparam logic [7:0] C_CH_P        = 8'h50;
    localparam logic [7:0] C_CH_C        = 8'h43;

endpackage

`default_nettype wire

// ===== hdl/tef_front.sv =====
// ----------------------------------------------------------------------------
// tef_front
// Escape parser: classifies each accepted byte and issues result commands.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_text_byte,
    input  wire logic          i_is_last,
    output logic               o_push,
    output tef_pkg::t_cmd      o_cmd
);

    tef_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_code, n_code;
    logic            r_ovr, n_ovr;
    logic            r_und, n_und;

    logic [7:0] up;
    logic [7:0] digit;
    logic       emit;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tef_pkg::PH_IDLE;
            r_code  <= '0;
            r_ovr   <= 1'b0;
            r_und   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_ovr   <= n_ovr;
            r_und   <= n_und;
        end
    end

    always_comb begin
        up    = (i_text_byte inside {[tef_pkg::C_LOWER_A:tef_pkg::C_LOWER_Z]})
              ? i_text_byte - tef_pkg::C_CASE_OFFSET : i_text_byte;
        digit = i_text_byte - tef_pkg::C_CH_ZERO;

        n_phase = r_phase;
        n_code  = r_code;
        n_ovr   = r_ovr;
        n_und   = r_und;
        emit    = 1'b0;
        two     = 1'b0;
        b0      = '0;
        b1      = '0;

        case (r_phase)
            tef_pkg::PH_PCT: begin
                if (i_text_byte == tef_pkg::C_PCT) begin
                    n_phase = tef_pkg::PH_ESC;
                end else begin
                    emit    = 1'b1;
                    two     = 1'b1;
                    b0      = tef_pkg::C_PCT;
                    b1      = i_text_byte;
                    n_phase = tef_pkg::PH_IDLE;
                end
            end
            tef_pkg::PH_ESC: begin
                n_phase = tef_pkg::PH_IDLE;
                if (up == tef_pkg::C_CH_O) begin
                    n_ovr = 1'b1;
                end else if (up == tef_pkg::C_CH_U) begin
                    n_und = 1'b1;
                end else if (up == tef_pkg::C_CH_D) begin
                    emit = 1'b1;
                    b0   = tef_pkg::C_CODE_D;
                end else if (up == tef_pkg::C_CH_P) begin
                    emit = 1'b1;
                    b0   = tef_pkg::C_CODE_P;
                end else if (up == tef_pkg::C_CH_C) begin
                    emit = 1'b1;
                    b0   = tef_pkg::C_CODE_C;
                end else if (i_text_byte == tef_pkg::C_PCT) begin
                    emit = 1'b1;
                    b0   = tef_pkg::C_PCT;
                end else if (i_text_byte inside
                             {[tef_pkg::C_CH_ZERO:tef_pkg::C_CH_NINE]}) begin
                    n_code  = digit * tef_pkg::C_HUNDRED;
                    n_phase = tef_pkg::PH_DIG1;
                end else begin
                    emit = 1'b1;
                    b0   = i_text_byte;
                end
            end
            tef_pkg::PH_DIG1: begin
                n_code  = r_code + digit * tef_pkg::C_TEN;
                n_phase = tef_pkg::PH_DIG2;
            end
            tef_pkg::PH_DIG2: begin
                emit    = 1'b1;
                b0      = r_code + digit;
                n_code  = '0;
                n_phase = tef_pkg::PH_IDLE;
            end
            default: begin
                if (i_text_byte == tef_pkg::C_PCT) begin
                    n_phase = tef_pkg::PH_PCT;
                end else begin
                    emit    = 1'b1;
                    b0      = i_text_byte;
                    n_phase = tef_pkg::PH_IDLE;
                end
            end
        endcase

        // flush a lone percent at end of text
        if (i_is_last && n_phase == tef_pkg::PH_PCT) begin
            emit = 1'b1;
            b0   = tef_pkg::C_PCT;
        end

        o_cmd.two = two;
        o_cmd.b0  = b0;
        o_cmd.b1  = b1;
        o_cmd.v0  = emit;
        o_cmd.eot = i_is_last;
        o_cmd.ovr = n_ovr;
        o_cmd.und = n_und;

        o_push = i_accept && (emit || i_is_last);

        if (i_is_last) begin
            n_phase = tef_pkg::PH_IDLE;
            n_code  = '0;
            n_ovr   = 1'b0;
            n_und   = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tef_queue.sv =====
// ----------------------------------------------------------------------------
// tef_queue
// Short command queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_queue #(
    parameter int DEPTH = tef_pkg::C_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tef_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output tef_pkg::t_cmd       o_head,
    output tef_pkg::t_q_status  o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    tef_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== hdl/tef_back.sv =====
// ----------------------------------------------------------------------------
// tef_back
// Output sequencer: expands queued commands into result items.
// ----------------------------------------------------------------------------
`default_nettype none

module tef_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tef_pkg::t_cmd  i_head,
    input  wire logic           i_head_valid,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_end_of_text,
    output logic                o_overscore,
    output logic                o_underscore
);

    logic       r_part, n_part;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_eot;
    logic       r_ovr;
    logic       r_und;

    logic load;
    logic last_part;

    always_comb begin
        load      = i_head_valid && (!r_valid || !i_stall);
        last_part = !i_head.two || r_part;
        n_part    = r_part;
        o_pop     = 1'b0;
        if (load) begin
            o_pop  = last_part;
            n_part = !last_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_part  <= 1'b0;
        end else begin
            r_part <= n_part;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= r_part ? i_head.b1 : i_head.b0;
            r_bv   <= r_part | i_head.v0;
            r_eot  <= i_head.eot && last_part;
            r_ovr  <= i_head.ovr;
            r_und  <= i_head.und;
        end
    end

    assign o_valid       = r_valid;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bv;
    assign o_end_of_text = r_eot;
    assign o_overscore   = r_ovr;
    assign o_underscore  = r_und;

    a_part_on_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part |-> (i_head_valid && i_head.two))
        else $error("second half pending without a paired command");

endmodule

`default_nettype wire

// ===== hdl/text_escape_filter.sv =====
// ----------------------------------------------------------------------------
// text_escape_filter
// Decodes double-percent escape codes in a byte stream into flags and result bytes.
// ----------------------------------------------------------------------------
// path: an accepted byte's command is written into the command queue,
//   and the output sequencer registers its result from the queue head
// throughput: one byte per cycle while the queue is not full; a percent
//   followed by another byte gives two results, sent one after the other
// the command queue (QUEUE_DEPTH entries) absorbs the extra result
// reset: synchronous, active low; clears parser phase, code, flags,
//   the queue and the output valid
// ----------------------------------------------------------------------------
`default_nettype none

module text_escape_filter #(
    parameter int QUEUE_DEPTH = tef_pkg::C_QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_is_last,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_text,
    output logic            o_overscore,
    output logic            o_underscore
);

    // queue status and the commands flowing through it
    tef_pkg::t_q_status q_status;
    tef_pkg::t_cmd      push_cmd;
    tef_pkg::t_cmd      head_cmd;
    logic               push;
    logic               pop;
    logic               accept;

    // stall the input only while the queue has no room for a command
    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    // front: parser state and classification of each transaction
    tef_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_is_last   (i_is_last),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // decouples the parser from output back-pressure
    tef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    // back: one result transaction per cycle from the queue head while the output is not stalled
    tef_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_cmd),
        .i_head_valid  (!q_status.empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_end_of_text (o_end_of_text),
        .o_overscore   (o_overscore),
        .o_underscore  (o_underscore)
    );

    // an empty result only closes a text, and then carries a zero byte
    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_end_of_text && o_out_byte == 8'd0))
        else $error("empty result outside end of text");

endmodule

`default_nettype wire
